// ----- rtl/vfvc_pkg.sv -----
package vfvc_pkg;

  // Chunk geometry. The cell index packs the coordinates as {y, z, x}.
  localparam int EDGE      = 16;
  localparam int EDGE_BITS = 4;
  localparam logic [EDGE_BITS-1:0] EDGE_MAX = EDGE_BITS'(EDGE - 1);

  // Widths of the request and response fields.
  localparam int INDEX_W = 3 * EDGE_BITS;
  localparam int BTYPE_W = 8;
  localparam int FACE_W  = 6;

  // Default store sizing, and the widest type id the store supports.
  localparam int CELLS_DEF     = 4096;
  localparam int TYPE_BITS_DEF = 8;
  localparam int TYPE_MAX_BITS = 16;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// ----- rtl/vfvc_store.sv -----
module vfvc_store #(
  parameter int CELLS     = vfvc_pkg::CELLS_DEF,
  parameter int TYPE_BITS = vfvc_pkg::TYPE_BITS_DEF,
  localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [AW-1:0]        addr,
  input  logic [TYPE_BITS:0]   wdata,
  output logic [TYPE_BITS:0]   rdata
);

  // Each word holds {air flag, type id}.
  logic [TYPE_BITS:0] mem [CELLS];

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/voxel_face_visibility_culler_top.sv -----
// Voxel face visibility culler.
// Requests arrive on the in_ channel (in_valid, in_stall) with req_type,
// cell_index, block_type and is_air; every request yields exactly one
// response on the out_ channel (out_valid, out_stall).
// A write request loads one cell and is acknowledged with all-zero fields.
// A query returns the six-bit exposed-face mask, the cell's type id and
// whether the cell is solid. Indexes at or beyond the store size are
// ignored on write and answered with zeros on query.
// All cells live in a single-port RAM, so a query reads the cell and then
// its six neighbours one per cycle; the response is registered after the last
// read returns, and a write's response after its RAM write. The block takes
// one request at a time, so throughput is bounded by the single RAM port.
// After reset the RAM is swept to air, one cell per cycle, over all CELLS
// cells (4096 by default); in_stall stays high during the sweep.
// A response waits in the output register while out_stall is high; the
// next request is still accepted and processed, and its result is held
// back until the output register is free.
module voxel_face_visibility_culler_top #(
  parameter int CELLS     = vfvc_pkg::CELLS_DEF,
  parameter int TYPE_BITS = vfvc_pkg::TYPE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [vfvc_pkg::INDEX_W-1:0]  cell_index,
  input  logic [vfvc_pkg::BTYPE_W-1:0]  block_type,
  input  logic                          is_air,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vfvc_pkg::FACE_W-1:0]   visible_faces,
  output logic [vfvc_pkg::BTYPE_W-1:0]  face_type,
  output logic                          is_solid
);

  localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EB  = vfvc_pkg::EDGE_BITS;
  localparam int IW  = vfvc_pkg::INDEX_W;
  localparam int TW  = vfvc_pkg::TYPE_MAX_BITS;
  localparam int XW  = 32;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_STEP   = 3'd2;
  localparam logic [2:0] ST_LAST   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Step 0 reads the cell itself, steps 1..6 its neighbours in mask order.
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_ZP     = 3'd1;
  localparam logic [2:0] STEP_ZN     = 3'd2;
  localparam logic [2:0] STEP_XN     = 3'd3;
  localparam logic [2:0] STEP_XP     = 3'd4;
  localparam logic [2:0] STEP_YP     = 3'd5;
  localparam logic [2:0] STEP_YN     = 3'd6;

  logic [2:0]                  state;
  logic [2:0]                  step;
  logic [AW-1:0]               clr_addr;
  logic                        req_q;
  logic [IW-1:0]               idx_q;
  logic [TYPE_BITS-1:0]        type_q;
  logic                        air_q;
  logic                        pend;
  logic                        pend_open;
  logic [2:0]                  pend_step;
  logic [vfvc_pkg::FACE_W-1:0] mask_acc;
  logic                        center_air;
  logic [vfvc_pkg::BTYPE_W-1:0] center_type;

  logic [EB-1:0]               x_q;
  logic [EB-1:0]               z_q;
  logic [EB-1:0]               y_q;
  logic [IW-1:0]               nb_idx;
  logic                        nb_in_chunk;
  logic                        rd_ok;
  logic [TW-1:0]               nb_ext;
  logic [TW-1:0]               btype_ext;
  logic [TW-1:0]               rtype_ext;
  logic [2:0]                  pend_bit;
  logic                        in_range;

  logic                        mem_en;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [TYPE_BITS:0]          mem_wdata;
  logic [TYPE_BITS:0]          mem_rdata;

  vfvc_store #(
    .CELLS     (CELLS),
    .TYPE_BITS (TYPE_BITS)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // Coordinates of the current cell.
  assign x_q = idx_q[EB-1:0];
  assign z_q = idx_q[2*EB-1:EB];
  assign y_q = idx_q[3*EB-1:2*EB];

  // Neighbour address for the current step and whether it lies in the chunk.
  always_comb begin
    nb_idx      = idx_q;
    nb_in_chunk = 1'b1;
    unique case (step)
      STEP_ZP: begin
        nb_in_chunk = (z_q != vfvc_pkg::EDGE_MAX);
        nb_idx      = {y_q, EB'(z_q + 1'b1), x_q};
      end
      STEP_ZN: begin
        nb_in_chunk = (z_q != '0);
        nb_idx      = {y_q, EB'(z_q - 1'b1), x_q};
      end
      STEP_XN: begin
        nb_in_chunk = (x_q != '0);
        nb_idx      = {y_q, z_q, EB'(x_q - 1'b1)};
      end
      STEP_XP: begin
        nb_in_chunk = (x_q != vfvc_pkg::EDGE_MAX);
        nb_idx      = {y_q, z_q, EB'(x_q + 1'b1)};
      end
      STEP_YP: begin
        nb_in_chunk = (y_q != vfvc_pkg::EDGE_MAX);
        nb_idx      = {EB'(y_q + 1'b1), z_q, x_q};
      end
      STEP_YN: begin
        nb_in_chunk = (y_q != '0);
        nb_idx      = {EB'(y_q - 1'b1), z_q, x_q};
      end
      default: begin
        nb_idx      = idx_q;
        nb_in_chunk = 1'b1;
      end
    endcase
  end

  assign rd_ok     = nb_in_chunk && (XW'(nb_idx) < XW'(CELLS));
  assign nb_ext    = TW'(nb_idx);
  assign btype_ext = TW'(block_type);
  assign rtype_ext = TW'(mem_rdata[TYPE_BITS-1:0]);
  assign pend_bit  = 3'(pend_step - 3'd1);
  assign in_range  = (XW'(cell_index) < XW'(CELLS));

  // RAM port: clearing sweep, cell write, or one read per step.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = nb_ext[AW-1:0];
    mem_wdata = {air_q, type_q};
    if (state == ST_CLEAR) begin
      mem_en    = 1'b1;
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = {1'b1, {TYPE_BITS{1'b0}}};
    end else if (state == ST_STEP) begin
      if (req_q == vfvc_pkg::REQ_WRITE) begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end else begin
        mem_en = rd_ok;
      end
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= STEP_CENTER;
      clr_addr  <= '0;
      pend      <= 1'b0;
      pend_step <= STEP_CENTER;
      out_valid <= 1'b0;
    end else begin
      // Every query step leaves one result to pick up on the next cycle.
      pend <= (state == ST_STEP) && (req_q == vfvc_pkg::REQ_QUERY);
      if (state == ST_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= AW'(clr_addr + 1'b1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            step  <= STEP_CENTER;
            state <= in_range ? ST_STEP : ST_FINISH;
          end
        end
        ST_STEP: begin
          pend_step <= step;
          if (req_q == vfvc_pkg::REQ_WRITE) begin
            state <= ST_FINISH;
          end else begin
            if (step == STEP_YN) begin
              state <= ST_LAST;
            end else begin
              step <= 3'(step + 3'd1);
            end
          end
        end
        ST_LAST: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture, neighbour accumulation and response register.
  always_ff @(posedge clk) begin
    // A neighbor outside the chunk is open without a read.
    pend_open <= !rd_ok;
    if (state == ST_IDLE && in_valid) begin
      req_q       <= req_type;
      idx_q       <= cell_index;
      type_q      <= btype_ext[TYPE_BITS-1:0];
      air_q       <= is_air;
      mask_acc    <= '0;
      center_air  <= 1'b1;
      center_type <= '0;
    end else begin
      // Read data returns in the cycle after its step.
      if (pend) begin
        if (pend_step == STEP_CENTER) begin
          center_air  <= mem_rdata[TYPE_BITS];
          center_type <= rtype_ext[vfvc_pkg::BTYPE_W-1:0];
        end else begin
          mask_acc[pend_bit] <= pend_open || mem_rdata[TYPE_BITS];
        end
      end
    end
    if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      face_type     <= center_type;
      is_solid      <= !center_air;
      visible_faces <= center_air ? '0 : mask_acc;
    end
  end

endmodule
